### rtl/bsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    // fixed width of the root result field
    localparam int ROOT_W = 24;

    // default fixed-point format, signed Q16.16
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // control that travels along the cell chain next to the data
    typedef struct packed {
        logic valid;
        logic neg;
    } t_ctrl;

endpackage

`default_nettype wire

### rtl/bsr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bsr_cell #(
    parameter int PAIRS = 24
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bsr_pkg::t_ctrl       i_ctrl,
    input  wire [PAIRS+1:0]      i_rem,
    input  wire [PAIRS-1:0]      i_root,
    input  wire [2*PAIRS-1:0]    i_rad,
    output bsr_pkg::t_ctrl       o_ctrl,
    output logic [PAIRS+1:0]     o_rem,
    output logic [PAIRS-1:0]     o_root,
    output logic [2*PAIRS-1:0]   o_rad
);
    import bsr_pkg::*;

    localparam int REM_W = PAIRS + 2;
    localparam int RAD_W = 2 * PAIRS;

    logic [REM_W-1:0] n_rem;
    logic [PAIRS-1:0] n_root;
    logic [RAD_W-1:0] n_rad;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    t_ctrl            r_ctrl;
    logic [REM_W-1:0] r_rem;
    logic [PAIRS-1:0] r_root;
    logic [RAD_W-1:0] r_rad;

    // bring down the next two radicand bits and try the next root bit
    always_comb begin
        rem_sh = {i_rem[REM_W-3:0], i_rad[RAD_W-1:RAD_W-2]};
        trial  = {i_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[PAIRS-2:0], fits};
        n_rad  = {i_rad[RAD_W-3:0], 2'b00};
    end

    // control moves to the neighbor every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    // data registers follow a valid item only
    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

`default_nettype wire

### rtl/bitwise_square_root.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    | ports                                | transfer when
// -----------+--------------------------------------+----------------------------
// operand in | start, busy, i_operand               | start high while busy low
// result out | o_done, o_root, o_negative_error     | o_done high, one cycle
//
// one item runs through a row of PAIRS = (DATA_WIDTH+FRAC_BITS+1)/2 cells,
// one root bit per cell and cycle, then the output register. busy stays high
// while the item is in any cell and drops in the cycle that o_done is high, so
// the row holds one item at a time; a new operand can be taken in that cycle.
// reset clears the valid flags along the chain and holds busy high while asserted.
// the receiver cannot stall: o_done is a single-cycle strobe.

module bitwise_square_root #(
    parameter int FRAC_BITS  = bsr_pkg::DEF_FRAC_BITS,
    parameter int DATA_WIDTH = bsr_pkg::DEF_DATA_WIDTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire signed [DATA_WIDTH-1:0]   i_operand,
    output logic [bsr_pkg::ROOT_W-1:0]    o_root,
    output logic                          o_negative_error,
    output logic                          o_done
);
    import bsr_pkg::*;

    localparam int TOTAL = DATA_WIDTH + FRAC_BITS;
    localparam int PAIRS = (TOTAL + 1) / 2;
    localparam int REM_W = PAIRS + 2;
    localparam int RAD_W = 2 * PAIRS;

    t_ctrl            chain_ctrl [PAIRS+1];
    logic [REM_W-1:0] chain_rem  [PAIRS+1];
    logic [PAIRS-1:0] chain_root [PAIRS+1];
    logic [RAD_W-1:0] chain_rad  [PAIRS+1];
    logic [PAIRS-1:0] valid_vec;

    logic              accept;
    logic [ROOT_W-1:0] root_sat;
    logic [ROOT_W-1:0] n_root;

    logic              r_done;
    logic              r_neg;
    logic [ROOT_W-1:0] r_root;

    // operand transfer feeds the first cell
    assign accept              = start && !busy;
    assign chain_ctrl[0].valid = accept;
    assign chain_ctrl[0].neg   = i_operand[DATA_WIDTH-1];
    assign chain_rem[0]        = '0;
    assign chain_root[0]       = '0;
    assign chain_rad[0]        = RAD_W'($unsigned(i_operand)) << FRAC_BITS;

    // row of root cells, one per radicand bit pair
    for (genvar g = 0; g < PAIRS; g++) begin : g_cell
        bsr_cell #(
            .PAIRS (PAIRS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (chain_ctrl[g]),
            .i_rem   (chain_rem[g]),
            .i_root  (chain_root[g]),
            .i_rad   (chain_rad[g]),
            .o_ctrl  (chain_ctrl[g+1]),
            .o_rem   (chain_rem[g+1]),
            .o_root  (chain_root[g+1]),
            .o_rad   (chain_rad[g+1])
        );
        assign valid_vec[g] = chain_ctrl[g+1].valid;
    end

    // final remainder is not needed
    logic unused_rem;
    assign unused_rem = ^{chain_rem[PAIRS], chain_rad[PAIRS]};

    assign busy = (|valid_vec) || !i_rst_n;

    // clamp the root into its field
    if (PAIRS > ROOT_W) begin : g_sat
        assign root_sat = (|chain_root[PAIRS][PAIRS-1:ROOT_W]) ? '1
                                                             : chain_root[PAIRS][ROOT_W-1:0];
    end else begin : g_nosat
        assign root_sat = ROOT_W'(chain_root[PAIRS]);
    end

    assign n_root = chain_ctrl[PAIRS].neg ? '0 : root_sat;

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= chain_ctrl[PAIRS].valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (chain_ctrl[PAIRS].valid) begin
            r_root <= n_root;
            r_neg  <= chain_ctrl[PAIRS].neg;
        end
    end

    assign o_done           = r_done;
    assign o_root           = r_root;
    assign o_negative_error = r_neg;

endmodule

`default_nettype wire

### rtl/bsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bsr_checker #(
    parameter int DATA_WIDTH = bsr_pkg::DEF_DATA_WIDTH
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          start,
    input wire                          busy,
    input wire [DATA_WIDTH-1:0]         i_operand,
    input wire [bsr_pkg::ROOT_W-1:0]    o_root,
    input wire                          o_negative_error,
    input wire                          o_done
);
    import bsr_pkg::*;

    // a negative operand always reports a zero root
    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_negative_error |-> o_root == '0)
        else $error("negative operand with nonzero root");

    // a transfer makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer did not raise busy");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a result follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without an item in flight");

    // operand is read only at transfer
    logic unused_op;
    assign unused_op = ^i_operand;

endmodule

bind bitwise_square_root bsr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_bsr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_operand        (i_operand),
    .o_root           (o_root),
    .o_negative_error (o_negative_error),
    .o_done           (o_done)
);

`default_nettype wire
